// ----- sv/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

  // Action codes carried on in_tuser.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  // Status codes carried on out_tuser.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/spq_cell.sv -----
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int COST_BITS  = 8,
  parameter int BOARD_BITS = 36
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic                  valid_i,
  input  wire logic [COST_BITS-1:0]  key_g_i,
  input  wire logic [COST_BITS-1:0]  key_h_i,
  input  wire logic [BOARD_BITS-1:0] key_board_i,
  input  wire logic [COST_BITS:0]    key_sum_i,
  input  wire logic [COST_BITS:0]    find_sum_i,
  input  wire logic [BOARD_BITS-1:0] find_board_i,
  input  wire logic                  prev_keep_i,
  input  wire logic [COST_BITS-1:0]  prev_g_i,
  input  wire logic [COST_BITS-1:0]  prev_h_i,
  input  wire logic [BOARD_BITS-1:0] prev_board_i,
  input  wire logic [COST_BITS-1:0]  next_g_i,
  input  wire logic [COST_BITS-1:0]  next_h_i,
  input  wire logic [BOARD_BITS-1:0] next_board_i,
  output logic                       keep_o,
  output logic                       match_o,
  output logic [COST_BITS-1:0]       g_o,
  output logic [COST_BITS-1:0]       h_o,
  output logic [BOARD_BITS-1:0]      board_o
);

  logic [COST_BITS-1:0]  g_r, g_nxt;
  logic [COST_BITS-1:0]  h_r, h_nxt;
  logic [BOARD_BITS-1:0] board_r, board_nxt;
  logic [COST_BITS:0]    own_sum;

  assign own_sum = {1'b0, g_r} + {1'b0, h_r};
  assign keep_o  = valid_i && (own_sum <= key_sum_i);
  assign match_o = valid_i && (own_sum <= find_sum_i) && (board_r == find_board_i);

  // An entry with a larger sum moves one place back; the first such place takes the key.
  always_comb begin
    g_nxt     = g_r;
    h_nxt     = h_r;
    board_nxt = board_r;
    if (ctrl_i.ins_en) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          g_nxt     = key_g_i;
          h_nxt     = key_h_i;
          board_nxt = key_board_i;
        end else begin
          g_nxt     = prev_g_i;
          h_nxt     = prev_h_i;
          board_nxt = prev_board_i;
        end
      end
    end else if (ctrl_i.pop_en) begin
      g_nxt     = next_g_i;
      h_nxt     = next_h_i;
      board_nxt = next_board_i;
    end
  end

  always_ff @(posedge clk) begin
    g_r     <= g_nxt;
    h_r     <= h_nxt;
    board_r <= board_nxt;
  end

  assign g_o     = g_r;
  assign h_o     = h_r;
  assign board_o = board_r;

endmodule
`default_nettype wire

// ----- sv/spq_or_tree.sv -----
`default_nettype none
module spq_or_tree #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] bits_i,
  output logic                  any_o
);

  function automatic int lvl_width(input int lv);
    int w;
    w = WIDTH;
    for (int k = 0; k < lv; k++) begin
      w = (w + 7) >> 3;
    end
    return w;
  endfunction

  function automatic int lvl_off(input int lv);
    int off;
    off = 0;
    for (int k = 0; k < lv; k++) begin
      off = off + lvl_width(k);
    end
    return off;
  endfunction

  function automatic int num_levels();
    int w;
    int n;
    w = WIDTH;
    n = 0;
    while (w > 1) begin
      w = (w + 7) >> 3;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int LEVELS = num_levels();
  localparam int TOTAL  = lvl_off(LEVELS + 1);

  logic [TOTAL-1:0] tree_r, tree_nxt;

  assign tree_nxt[WIDTH-1:0] = bits_i;

  // Each node above the leaves ORs up to eight nodes of the level below.
  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int PW   = lvl_width(lv - 1);
    localparam int POFF = lvl_off(lv - 1);
    localparam int OFF  = lvl_off(lv);
    for (genvar j = 0; j < lvl_width(lv); j++) begin : g_node
      localparam int N = ((PW - 8 * j) < 8) ? (PW - 8 * j) : 8;
      assign tree_nxt[OFF + j] = |tree_r[POFF + 8 * j +: N];
    end
  end

  always_ff @(posedge clk) begin
    tree_r <= tree_nxt;
  end

  assign any_o = tree_r[lvl_off(LEVELS)];

endmodule
`default_nettype wire

// ----- sv/sorted_priority_queue.sv -----
`default_nettype none
// Sorted priority queue for the open list of a best-first search.
//
// Requests arrive on the in_ channel: in_tuser selects insert, pop of the
// head or find, and in_tdata carries the path cost, the estimate cost and the
// board. Entries are held in a chain of cells, ordered by the sum of the two
// costs; a new entry goes behind every entry of equal or lower sum. Each
// request yields exactly one result on the out_ channel with the status, the
// find flag, the head entry and the entry count after the request.
//
// Insert and pop shift the whole chain in the cycle the request is accepted.
// Find compares every cell at once and ORs the hits through a registered tree
// of eight-input nodes. A new request is taken only in the idle state, once
// the result of the last one has gone to the output register.
//
// Reset empties the queue and drops any result not yet taken; cell contents
// are left as they are. While the receiver holds out_tready low the result
// waits in the output register; one further request is still accepted and
// executed, and its result follows once the waiting one has been taken.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int BOARD_BITS  = 36,
  parameter int COST_BITS   = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: path_cost, estimate_cost, board, zero padding.
  input  wire logic [((2*COST_BITS+BOARD_BITS+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0: action.
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // Fields from bit 0: head_path_cost, head_estimate_cost, head_board,
  // entry_count, zero padding.
  output logic [((2*COST_BITS+BOARD_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: status (2 bits), found.
  output logic [2:0]                     out_tuser
);

  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PAY_W      = 2 * COST_BITS + BOARD_BITS;
  localparam int OUT_DATA_W = ((PAY_W + CNT_W + 7) / 8) * 8;

  function automatic int tree_levels();
    int w;
    int n;
    w = QUEUE_DEPTH;
    n = 0;
    while (w > 1) begin
      w = (w + 7) >> 3;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int LEVELS = tree_levels();
  localparam int WAIT_W = $clog2(LEVELS + 2);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FIND   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [WAIT_W-1:0]     wait_r, wait_nxt;
  logic [COST_BITS:0]    find_sum_r, find_sum_nxt;
  logic [BOARD_BITS-1:0] find_board_r, find_board_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]            out_user_r, out_user_nxt;

  logic [COST_BITS-1:0]  key_g, key_h;
  logic [BOARD_BITS-1:0] key_board;
  logic [COST_BITS:0]    key_sum;
  logic                  in_fire;
  logic                  out_free;
  logic                  found_any;
  cell_ctrl_t            cell_ctrl;

  logic [COST_BITS-1:0]  cell_g [QUEUE_DEPTH];
  logic [COST_BITS-1:0]  cell_h [QUEUE_DEPTH];
  logic [BOARD_BITS-1:0] cell_board [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_keep;
  logic [QUEUE_DEPTH-1:0] cell_match;

  assign key_g     = in_tdata[COST_BITS-1:0];
  assign key_h     = in_tdata[2*COST_BITS-1:COST_BITS];
  assign key_board = in_tdata[PAY_W-1:2*COST_BITS];
  assign key_sum   = {1'b0, key_g} + {1'b0, key_h};

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // The chain shifts only in the cycle a request is accepted.
  always_comb begin
    cell_ctrl.ins_en = in_fire && (in_tuser == ACT_INSERT)
                       && (count_r != CNT_W'(QUEUE_DEPTH));
    cell_ctrl.pop_en = in_fire && (in_tuser == ACT_POP) && (count_r != '0);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  prev_keep;
    logic [COST_BITS-1:0]  prev_g, prev_h, next_g, next_h;
    logic [BOARD_BITS-1:0] prev_board, next_board;

    // The head cell sees the key as its front neighbor; the last cell
    // refills from itself on a pop, beyond the held entries.
    if (i == 0) begin : g_first
      assign prev_keep  = 1'b1;
      assign prev_g     = key_g;
      assign prev_h     = key_h;
      assign prev_board = key_board;
    end else begin : g_mid
      assign prev_keep  = cell_keep[i-1];
      assign prev_g     = cell_g[i-1];
      assign prev_h     = cell_h[i-1];
      assign prev_board = cell_board[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_g     = cell_g[i];
      assign next_h     = cell_h[i];
      assign next_board = cell_board[i];
    end else begin : g_body
      assign next_g     = cell_g[i+1];
      assign next_h     = cell_h[i+1];
      assign next_board = cell_board[i+1];
    end

    spq_cell #(
      .COST_BITS  (COST_BITS),
      .BOARD_BITS (BOARD_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl_i       (cell_ctrl),
      .valid_i      (CNT_W'(i) < count_r),
      .key_g_i      (key_g),
      .key_h_i      (key_h),
      .key_board_i  (key_board),
      .key_sum_i    (key_sum),
      .find_sum_i   (find_sum_r),
      .find_board_i (find_board_r),
      .prev_keep_i  (prev_keep),
      .prev_g_i     (prev_g),
      .prev_h_i     (prev_h),
      .prev_board_i (prev_board),
      .next_g_i     (next_g),
      .next_h_i     (next_h),
      .next_board_i (next_board),
      .keep_o       (cell_keep[i]),
      .match_o      (cell_match[i]),
      .g_o          (cell_g[i]),
      .h_o          (cell_h[i]),
      .board_o      (cell_board[i])
    );
  end

  spq_or_tree #(
    .WIDTH (QUEUE_DEPTH)
  ) u_or_tree (
    .clk    (clk),
    .bits_i (cell_match),
    .any_o  (found_any)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    wait_nxt       = wait_r;
    find_sum_nxt   = find_sum_r;
    find_board_nxt = find_board_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_tuser;
          status_nxt = STAT_OK;
          state_nxt  = S_RESULT;
          case (in_tuser)
            ACT_INSERT: begin
              if (cell_ctrl.ins_en) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            ACT_POP: begin
              if (cell_ctrl.pop_en) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                status_nxt = STAT_EMPTY;
              end
            end
            ACT_FIND: begin
              find_sum_nxt   = key_sum;
              find_board_nxt = key_board;
              wait_nxt       = '0;
              state_nxt      = S_FIND;
            end
            default: begin
              status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_FIND: begin
        // Wait for the match bits to climb the OR tree.
        wait_nxt = wait_r + WAIT_W'(1);
        if (wait_r == WAIT_W'(LEVELS)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = {(op_r == ACT_FIND) && found_any, status_r};
          out_data_nxt  = '0;
          out_data_nxt[PAY_W+CNT_W-1:PAY_W] = count_r;
          if (count_r != '0) begin
            out_data_nxt[PAY_W-1:0] = {cell_board[0], cell_h[0], cell_g[0]};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    wait_r       <= wait_nxt;
    find_sum_r   <= find_sum_nxt;
    find_board_r <= find_board_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ----- dv/sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 180;
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam logic [35:0] BOARD_ONES = 36'hF_FFFF_FFFF;

  // One entry of the open list as the queue holds it.
  typedef struct packed {
    logic [7:0]  path_cost;
    logic [7:0]  estimate_cost;
    logic [35:0] board;
  } open_entry_t;

  // One result of the queue, unpacked from out_tdata and out_tuser.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  head_path_cost;
    logic [7:0]  head_estimate_cost;
    logic [35:0] head_board;
    logic [6:0]  entry_count;
  } queue_reply_t;

  // Mirror of the open list. Every accepted request updates the mirror and
  // queues the reply that the block must give for it; replies come back in
  // request order, so each one is checked against the oldest waiting reply.
  class open_list_model;
    open_entry_t  held[$];
    queue_reply_t pending_replies[$];
    int           failures;

    function logic [8:0] entry_sum(open_entry_t e);
      return {1'b0, e.path_cost} + {1'b0, e.estimate_cost};
    endfunction

    function void apply_request(logic [1:0] action, logic [7:0] g, logic [7:0] h,
                                logic [35:0] board);
      queue_reply_t r;
      open_entry_t  e;
      logic [8:0]   key_sum;
      int           pos;
      r = '0;
      key_sum = {1'b0, g} + {1'b0, h};
      e.path_cost = g;
      e.estimate_cost = h;
      e.board = board;
      case (action)
        ACT_INSERT: begin
          if (held.size() >= QUEUE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            // The new entry goes behind every entry of equal or lower sum.
            pos = 0;
            while (pos < held.size() && entry_sum(held[pos]) <= key_sum) pos++;
            held.insert(pos, e);
          end
        end
        ACT_POP: begin
          if (held.size() == 0) r.status = STAT_EMPTY;
          else void'(held.pop_front());
        end
        ACT_FIND: begin
          // The list is sorted, so the scan stops at the first larger sum.
          for (int i = 0; i < held.size(); i++) begin
            if (entry_sum(held[i]) > key_sum) break;
            if (held[i].board == board) begin
              r.found = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      if (held.size() > 0) begin
        r.head_path_cost = held[0].path_cost;
        r.head_estimate_cost = held[0].estimate_cost;
        r.head_board = held[0].board;
      end
      r.entry_count = 7'(held.size());
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [35:0] want, logic [35:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_reply(logic [63:0] tdata, logic [2:0] tuser);
      queue_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply 0x%0h / 0x%0h arrived with no request outstanding", tdata, tuser);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", 36'(want.status), 36'(tuser[1:0]));
      compare_field("found", 36'(want.found), 36'(tuser[2]));
      compare_field("head_path_cost", 36'(want.head_path_cost), 36'(tdata[7:0]));
      compare_field("head_estimate_cost", 36'(want.head_estimate_cost), 36'(tdata[15:8]));
      compare_field("head_board", want.head_board, tdata[51:16]);
      compare_field("entry_count", 36'(want.entry_count), 36'(tdata[58:52]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  open_list_model queue_model;

  // Idling is switched off for some phases so that back-to-back traffic is
  // also covered. A hold-off request makes the receiver stall for a long time.
  bit idle_enabled = 1'b1;
  bit hold_off_request = 1'b0;

  // Boards recently offered for insert, so that finds hit held entries.
  logic [35:0] recent_board[16];
  logic [7:0]  recent_g[16];
  logic [7:0]  recent_h[16];
  int          recent_fill = 0;

  always #5 clk = ~clk;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // path_cost, estimate_cost, board, zero padding
    .in_tuser  (in_tuser),   // action
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // head_path_cost, head_estimate_cost, head_board,
                             // entry_count, zero padding
    .out_tuser (out_tuser)   // status, found
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Costs: mostly a narrow range so that equal sums and find hits are common.
  function automatic logic [7:0] pick_cost();
    if ($urandom_range(99) < 60) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [35:0] random_board();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[35:0];
  endfunction

  // Offers one request, waits for it to be accepted and notes it in the
  // mirror. Valid is left high when no gap follows; the next request or
  // wait_for_replies takes it over at the next falling edge.
  task automatic send_request(logic [1:0] action, logic [7:0] g, logic [7:0] h,
                              logic [35:0] board);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {4'b0, board, h, g};
    do @(posedge clk); while (!in_tready);
    queue_model.apply_request(action, g, h, board);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops offering requests and waits until every reply has been taken.
  task automatic wait_for_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (queue_model.pending_replies.size() != 0) @(posedge clk);
  endtask

  // Receiver: ready most of the time with random stalls, and one long
  // hold-off on request, counted here in cycles.
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Every reply taken is checked at the rising edge it is accepted on.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) queue_model.check_reply(out_tdata, out_tuser);
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #5_000_000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

  initial begin
    // Insert weight of each random phase: high weights fill the queue up to
    // the refused insert, low weights drain it to the empty pop.
    int insert_weight[8];
    int r;
    int k;
    logic [1:0]  action;
    logic [7:0]  g;
    logic [7:0]  h;
    logic [35:0] board;

    insert_weight = '{70, 70, 20, 45, 80, 15, 45, 60};
    queue_model = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Empty queue first: pop, find and the undefined action.
    send_request(ACT_POP, 8'd0, 8'd0, 36'h0);
    send_request(ACT_FIND, 8'd0, 8'd0, 36'h0);
    send_request(ACT_UNDEFINED, 8'd255, 8'd255, BOARD_ONES);
    // Fill with extreme costs and equal sums; equal sums keep arrival order,
    // and the largest sum needs the extra bit.
    send_request(ACT_INSERT, 8'd10, 8'd20, 36'h1_2345_6780);
    send_request(ACT_INSERT, 8'd0, 8'd0, 36'h0);
    send_request(ACT_INSERT, 8'd255, 8'd255, BOARD_ONES);
    send_request(ACT_INSERT, 8'd20, 8'd10, 36'h8_7654_3210);
    send_request(ACT_INSERT, 8'd30, 8'd0, 36'h1_2345_6780);
    // Finds: equal sum hits, one lower misses, a board that is not held
    // scans the whole list.
    send_request(ACT_FIND, 8'd15, 8'd15, 36'h1_2345_6780);
    send_request(ACT_FIND, 8'd14, 8'd15, 36'h1_2345_6780);
    send_request(ACT_FIND, 8'd255, 8'd255, BOARD_ONES);
    send_request(ACT_FIND, 8'd255, 8'd254, BOARD_ONES);
    send_request(ACT_FIND, 8'd255, 8'd255, 36'h0_0000_0001);
    send_request(ACT_UNDEFINED, 8'd0, 8'd0, 36'h0);
    send_request(ACT_INSERT, 8'd255, 8'd0, 36'hA_5A5A_5A5A);
    send_request(ACT_INSERT, 8'd0, 8'd255, 36'h5_A5A5_A5A5);
    send_request(ACT_FIND, 8'd0, 8'd0, 36'h8_7654_3210);
    send_request(ACT_FIND, 8'd0, 8'd0, 36'h0);
    // Drain in order, then one pop too many.
    repeat (8) send_request(ACT_POP, 8'd0, 8'd0, 36'h0);
    wait_for_replies();

    // Random part, in phases of different mix and idling.
    for (int phase = 0; phase < 8; phase++) begin
      idle_enabled = !(phase == 1 || phase == 5);
      // The block fills up and stalls its input while the receiver holds off.
      if (phase == 2) hold_off_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        g = pick_cost();
        h = pick_cost();
        if (r < 2) begin
          action = ACT_UNDEFINED;
          board = random_board();
        end else if (r < 2 + insert_weight[phase]) begin
          action = ACT_INSERT;
          if (recent_fill > 0 && $urandom_range(99) < 30)
            board = recent_board[$urandom_range(recent_fill - 1)];
          else
            board = random_board();
          k = $urandom_range(15);
          recent_board[k] = board;
          recent_g[k] = g;
          recent_h[k] = h;
          if (recent_fill <= k) recent_fill = k + 1;
        end else if (r < 27 + insert_weight[phase]) begin
          action = ACT_FIND;
          if (recent_fill > 0 && $urandom_range(99) < 70) begin
            // Key near a recent entry's sum, to land on both sides of it.
            k = $urandom_range(recent_fill - 1);
            board = recent_board[k];
            g = recent_g[k];
            h = recent_h[k];
            case ($urandom_range(2))
              0: if (g != 8'd0) g = g - 8'd1;
              1: if (h != 8'd255) h = h + 8'd1;
              default: ;
            endcase
          end else begin
            board = random_board();
          end
        end else begin
          action = ACT_POP;
          board = random_board();
        end
        send_request(action, g, h, board);
      end
      // Now and then the sender pauses until the queue has answered all.
      if (phase == 3 || phase == 6) wait_for_replies();
    end

    wait_for_replies();
    repeat (20) @(posedge clk);
    if (queue_model.failures == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_or_tree.sv
sv/sorted_priority_queue.sv
dv/sorted_priority_queue_test.sv
